// ===== hdl/lmmn_pkg.sv =====
// Package for the log min-max normaliser: widths, status and request codes,
// controller state type and command/status structs. No dependencies.
`default_nettype none
package lmmn_pkg;
	localparam int VALUE_BITS_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int LOG_W          = 22;
	localparam int LOG_FRAC       = 16;
	localparam int OUT_W          = 17;
	localparam int MANT_W         = 32;          // Q2.30 while squaring
	localparam logic [LOG_W-1:0] LOG_ONE = 22'h010000;
	localparam logic [LOG_W-1:0] LOG_SAT = 22'h3FFFFF;

	localparam logic REQ_SEED = 1'b0;
	localparam logic REQ_NORM = 1'b1;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_UNSEEDED = 2'd1;
	localparam logic [1:0] ST_RANGE    = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOG,      // log of one operand in progress
		S_DIV,      // division in progress
		S_OUT       // result waiting for the receiver
	} state_t;

	typedef struct packed {
		logic load;       // capture request
		logic log_start;  // start log unit on selected operand
		logic log_sel_hi; // 0: low/sample operand, 1: range high
		logic log_store;  // store finished log result
		logic div_start;
		logic out_load;   // capture result into output register
	} cmd_t;

	typedef struct packed {
		logic need_log;   // request needs logs computed
		logic need_hi;    // seed also needs log of range high
		logic need_div;   // normalise in range needs division
		logic log_done;
		logic div_done;
	} sts_t;
endpackage
`default_nettype wire

// ===== hdl/lmmn_ctrl.sv =====
// Controller state machine of the log min-max normaliser.
// Depends on lmmn_pkg.
`default_nettype none
module lmmn_ctrl (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_fire,
	input  wire logic         out_fire,
	input  wire lmmn_pkg::sts_t sts,
	output lmmn_pkg::cmd_t    cmd,
	output logic              in_rdy,
	output logic              out_vld
);
	lmmn_pkg::state_t state_q, state_d;
	logic hi_phase_q;     // second log of a seed
	logic out_full_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			lmmn_pkg::S_IDLE: begin
				if (in_fire) state_d = lmmn_pkg::S_LOG;
			end
			lmmn_pkg::S_LOG: begin
				if (!sts.need_log) state_d = lmmn_pkg::S_OUT;
				else if (sts.log_done) begin
					if (sts.need_div) state_d = lmmn_pkg::S_DIV;
					else if (sts.need_hi && !hi_phase_q) state_d = lmmn_pkg::S_LOG;
					else state_d = lmmn_pkg::S_OUT;
				end
			end
			lmmn_pkg::S_DIV: begin
				if (sts.div_done) state_d = lmmn_pkg::S_OUT;
			end
			lmmn_pkg::S_OUT: begin
				if (!out_full_q || out_fire) state_d = lmmn_pkg::S_IDLE;
			end
			default: state_d = lmmn_pkg::S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd = '0;
		in_rdy = 1'b0;
		case (state_q)
			lmmn_pkg::S_IDLE: begin
				in_rdy = 1'b1;
				cmd.load = in_fire;
			end
			lmmn_pkg::S_LOG: begin
				cmd.log_sel_hi = hi_phase_q;
				cmd.log_start = (state_d == lmmn_pkg::S_LOG) && !sts.log_done;
				cmd.log_store = sts.need_log && sts.log_done;
				cmd.div_start = sts.log_done && sts.need_div;
			end
			lmmn_pkg::S_OUT: begin
				cmd.out_load = !out_full_q || out_fire;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= lmmn_pkg::S_IDLE;
			hi_phase_q <= 1'b0;
			out_full_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) hi_phase_q <= 1'b0;
			else if (state_q == lmmn_pkg::S_LOG && sts.log_done) hi_phase_q <= 1'b1;
			if (cmd.out_load) out_full_q <= 1'b1;
			else if (out_fire) out_full_q <= 1'b0;
		end
	end
	assign out_vld = out_full_q;

	// at most one item in flight: no input while busy
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != lmmn_pkg::S_IDLE) |-> !in_rdy) else $error("ready while busy");
	a_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> (state_q == lmmn_pkg::S_DIV)) else $error("division lost");
	a_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_vld) else $error("result not shown");
endmodule
`default_nettype wire

// ===== hdl/lmmn_dp.sv =====
// Datapath of the log min-max normaliser: range registers, iterative log2
// unit (one squaring per cycle), radix-2 divider, output register. Uses lmmn_pkg.
`default_nettype none
module lmmn_dp #(
	parameter int VALUE_BITS = lmmn_pkg::VALUE_BITS_DEF,
	parameter int FRAC_BITS  = lmmn_pkg::FRAC_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire lmmn_pkg::cmd_t        cmd,
	input  wire logic                  req_in,
	input  wire logic [VALUE_BITS-1:0] val_in,
	output lmmn_pkg::sts_t             sts,
	output logic [lmmn_pkg::OUT_W-1:0] frac_out,
	output logic [1:0]                 status_out
);
	localparam int EW = $clog2(VALUE_BITS + 1);
	localparam int SW = $clog2(lmmn_pkg::LOG_FRAC + 1);
	localparam int NUM_W = lmmn_pkg::LOG_W + FRAC_BITS;
	localparam int QCNT_W = $clog2(NUM_W + 1);
	localparam logic [VALUE_BITS-1:0] VMAX = '1;

	// request and range state
	logic                  req_q;
	logic [VALUE_BITS-1:0] v_q, lo_q, hi_q;
	logic                  seeded_q;
	logic [lmmn_pkg::LOG_W-1:0] log_low_q, log_span_q;
	logic [1:0]            st_q;
	logic                  chg_q;   // seed widened the range

	wire logic in_lo = (val_in < lo_q);
	wire logic in_hi = (val_in > hi_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seeded_q <= 1'b0;
			lo_q <= '0;
			hi_q <= '0;
		end else if (cmd.load && req_in == lmmn_pkg::REQ_SEED) begin
			seeded_q <= 1'b1;
			if (!seeded_q) begin
				lo_q <= val_in;
				hi_q <= val_in;
			end else if (in_lo) lo_q <= val_in;
			else if (in_hi) hi_q <= val_in;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req_in;
			v_q   <= val_in;
			chg_q <= !seeded_q || in_lo || in_hi;
			if (req_in == lmmn_pkg::REQ_SEED) st_q <= lmmn_pkg::ST_OK;
			else if (!seeded_q) st_q <= lmmn_pkg::ST_UNSEEDED;
			else if (in_lo || in_hi) st_q <= lmmn_pkg::ST_RANGE;
			else st_q <= lmmn_pkg::ST_OK;
		end
	end

	wire logic seed_w = (req_q == lmmn_pkg::REQ_SEED);
	assign sts.need_log = seed_w ? chg_q : (st_q == lmmn_pkg::ST_OK);
	assign sts.need_hi  = seed_w;
	assign sts.need_div = !seed_w;

	// log operand: normalise uses sample, seed uses low then high
	logic [VALUE_BITS-1:0] op;
	always_comb begin
		if (!seed_w) op = v_q;
		else if (cmd.log_sel_hi) op = hi_q;
		else op = lo_q;
	end

	// log unit: leading-one at start, then one squaring per cycle
	logic               lg_busy_q, lg_sat_q;
	logic [EW-1:0]      lg_e_q;
	logic [lmmn_pkg::MANT_W-1:0] lg_m_q;
	logic [lmmn_pkg::LOG_FRAC-1:0] lg_f_q;
	logic [SW-1:0]      lg_cnt_q;
	logic               lg_done_q;

	logic [VALUE_BITS:0] x;
	logic [EW-1:0]       e_w;
	logic [VALUE_BITS+30:0] xs;
	always_comb begin
		x = {1'b0, op} + {{VALUE_BITS{1'b0}}, 1'b1};
		e_w = '0;
		for (int i = 0; i <= VALUE_BITS; i++)
			if (x[i]) e_w = EW'(i);
		xs = {30'd0, x} << 30;
		xs = xs >> e_w;
	end

	wire logic [2*lmmn_pkg::MANT_W-1:0] sq = lg_m_q * lg_m_q;
	wire logic [lmmn_pkg::MANT_W-1:0] sq_s = sq[30 +: lmmn_pkg::MANT_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lg_busy_q <= 1'b0;
			lg_done_q <= 1'b0;
		end else begin
			lg_done_q <= 1'b0;
			if (cmd.log_start && !lg_busy_q && !lg_done_q) begin
				lg_busy_q <= 1'b1;
				lg_cnt_q  <= '0;
				lg_e_q    <= e_w;
				lg_sat_q  <= x[VALUE_BITS] && (VALUE_BITS == 64);
				lg_m_q    <= xs[lmmn_pkg::MANT_W-1:0];
				lg_f_q    <= '0;
			end else if (lg_busy_q) begin
				lg_f_q <= {lg_f_q[lmmn_pkg::LOG_FRAC-2:0], sq_s[31]};
				lg_m_q <= sq_s[31] ? (sq_s >> 1) : sq_s;
				lg_cnt_q <= lg_cnt_q + 1'b1;
				if (lg_cnt_q == SW'(lmmn_pkg::LOG_FRAC - 1)) begin
					lg_busy_q <= 1'b0;
					lg_done_q <= 1'b1;
				end
			end
		end
	end
	assign sts.log_done = lg_done_q;
	wire logic [lmmn_pkg::LOG_W-1:0] lg_res = lg_sat_q ? lmmn_pkg::LOG_SAT :
		lmmn_pkg::LOG_W'({lg_e_q, lg_f_q});

	// log store: seed keeps low log then span; normalise feeds the divider
	wire logic [lmmn_pkg::LOG_W-1:0] span_w =
		(lg_res >= log_low_q) ? lg_res - log_low_q : '0;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log_low_q  <= '0;
			log_span_q <= '0;
		end else if (cmd.log_store && seed_w) begin
			if (!cmd.log_sel_hi) log_low_q <= lg_res;
			else log_span_q <= span_w;
		end
	end

	// restoring divider, one quotient bit per cycle
	logic              dv_busy_q, dv_done_q;
	logic [NUM_W-1:0]  dv_n_q, dv_qt_q;
	logic [lmmn_pkg::LOG_W:0] dv_r_q;
	logic [lmmn_pkg::LOG_W-1:0] dv_d_q;
	logic [QCNT_W-1:0] dv_cnt_q;
	wire logic [lmmn_pkg::LOG_W-1:0] num_a =
		(lg_res >= log_low_q) ? lg_res - log_low_q : '0;
	wire logic [lmmn_pkg::LOG_W+1:0] trial = {dv_r_q, dv_n_q[NUM_W-1]};
	wire logic ge = (trial >= {2'b00, dv_d_q});
	wire logic [lmmn_pkg::LOG_W+1:0] diff = trial - {2'b00, dv_d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_busy_q <= 1'b0;
			dv_done_q <= 1'b0;
		end else begin
			dv_done_q <= 1'b0;
			if (cmd.div_start) begin
				dv_busy_q <= 1'b1;
				dv_n_q  <= {num_a, {FRAC_BITS{1'b0}}};
				dv_r_q  <= '0;
				dv_qt_q <= '0;
				dv_d_q  <= (log_span_q == '0) ? lmmn_pkg::LOG_ONE : log_span_q;
				dv_cnt_q <= '0;
			end else if (dv_busy_q) begin
				dv_r_q  <= ge ? diff[lmmn_pkg::LOG_W:0] : trial[lmmn_pkg::LOG_W:0];
				dv_n_q  <= dv_n_q << 1;
				dv_qt_q <= {dv_qt_q[NUM_W-2:0], ge};
				dv_cnt_q <= dv_cnt_q + 1'b1;
				if (dv_cnt_q == QCNT_W'(NUM_W - 1)) begin
					dv_busy_q <= 1'b0;
					dv_done_q <= 1'b1;
				end
			end
		end
	end
	assign sts.div_done = dv_done_q;

	localparam logic [NUM_W-1:0] LIM = NUM_W'(1) << FRAC_BITS;
	wire logic [NUM_W-1:0] q_sat = (dv_qt_q > LIM) ? LIM : dv_qt_q;

	// output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			frac_out   <= (!seed_w && st_q == lmmn_pkg::ST_OK) ?
				lmmn_pkg::OUT_W'(q_sat) : '0;
			status_out <= st_q;
		end
	end

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		seeded_q |-> (lo_q <= hi_q)) else $error("range inverted");
	a_span: assert property (@(posedge clk) disable iff (!arst_n)
		!(lg_busy_q && dv_busy_q)) else $error("units overlap");
	a_max: assert property (@(posedge clk) disable iff (!arst_n)
		(lo_q != VMAX) || (hi_q == VMAX)) else $error("range high below low");
endmodule
`default_nettype wire

// ===== hdl/log_min_max_normalizer_top.sv =====
// Log min-max normaliser, top level. One stream in, one stream out.
//
// Input transfer: s_tuser = request kind (0 seed, 1 normalise), s_tdata = value.
// Output transfer: m_tdata = {status, norm_fraction}, fraction in bits 16:0,
// status in bits 18:17. Exactly one result per input item, in order.
// A seed widening the range computes two base-2 logs (each: start, 16
// squarings, store); a normalise in range computes one log and a
// restoring division of 38 quotient bits. Items needing no log skip the
// log unit and the divider. One item is in flight at a time, so the next
// input is taken only after the previous result has been loaded into the
// output register; the log unit (one squaring per cycle) and the
// bit-serial divider set how soon that is.
// Reset clears the range and the seeded flag; the first seed sets both bounds.
// If the receiver stalls the result waits in the output register; the next
// item may still be taken, but its result is held until that one has gone.
`default_nettype none
module log_min_max_normalizer_top #(
	parameter int VALUE_BITS = lmmn_pkg::VALUE_BITS_DEF,
	parameter int FRAC_BITS  = lmmn_pkg::FRAC_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [VALUE_BITS-1:0] s_tdata,   // sample_value
	input  wire logic                  s_tuser,   // req_type
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [23:0]                m_tdata    // norm_fraction, status
);
	lmmn_pkg::cmd_t cmd;
	lmmn_pkg::sts_t sts;
	logic [lmmn_pkg::OUT_W-1:0] frac;
	logic [1:0] st;

	lmmn_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_fire(s_tvalid && s_tready), .out_fire(m_tvalid && m_tready),
		.sts(sts), .cmd(cmd), .in_rdy(s_tready), .out_vld(m_tvalid)
	);

	lmmn_dp #(.VALUE_BITS(VALUE_BITS), .FRAC_BITS(FRAC_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.req_in(s_tuser), .val_in(s_tdata),
		.sts(sts), .frac_out(frac), .status_out(st)
	);

	assign m_tdata = {5'd0, st, frac};
endmodule
`default_nettype wire
